// ----- rtl/core/bspack_pkg.sv -----
// Shared types and constants of the aligned-literal bitstream packer.
`default_nettype none
package bspack_pkg;

	localparam int MAX_SYMBOL_BITS = 24;
	localparam int SYM_W           = 24;
	localparam int OUT_ADDR_W      = 17;
	localparam int MAX_RESULTS     = 4;

	localparam logic [1:0] OP_CODE    = 2'd0;
	localparam logic [1:0] OP_LITERAL = 2'd1;
	localparam logic [1:0] OP_FLUSH   = 2'd2;

	localparam logic [7:0] SHIFT_RESET = 8'hFF;
	localparam logic [7:0] SLOT_FILL   = 8'h00;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [4:0]       bit_count;
		logic [SYM_W-1:0] sym_value;
	} in_item_t;

	typedef struct packed {
		logic                  write_enable;
		logic [OUT_ADDR_W-1:0] write_addr;
		logic [7:0]            write_data;
		logic                  last;
	} out_item_t;

	typedef struct packed {
		logic                  we;
		logic [OUT_ADDR_W-1:0] addr;
		logic [7:0]            data;
	} wr_entry_t;

	// cnt is the number of results of one item, 1 to MAX_RESULTS
	typedef struct packed {
		logic [2:0]                       cnt;
		wr_entry_t [MAX_RESULTS-1:0]      entry;
	} wr_list_t;

	typedef struct packed {
		logic [7:0] shift_byte;
		logic [2:0] pend;
		logic       slot_open;
	} bit_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/bitstream_packer_aligned_literals.sv -----
// Top level of the aligned-literal bitstream packer.
// Packs code words MSB first into bytes and writes byte-aligned literals between
// them; each result is one (address, byte) memory write, and the last result of
// an item carries last. An item gives one result per write that it causes:
// one result for an item with one write (or none, which still gives one empty
// result), up to four for a literal of three bytes behind a reserved slot.
// The single result port hands out one write per cycle while result_stall is
// low, from a four-entry result buffer; the input register takes the next item
// while the buffer still drains. Write addresses wrap at ADDR_BITS bits and
// leave the port as 17 bits.
`default_nettype none
module bitstream_packer_aligned_literals #(
	parameter int ADDR_BITS = 17
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        item_valid,
	output logic                       item_stall,
	input  wire bspack_pkg::in_item_t  item,
	output logic                       result_valid,
	input  wire                        result_stall,
	output bspack_pkg::out_item_t      result
);

	bspack_pkg::in_item_t   item_s1;
	logic                   valid_s1;
	bspack_pkg::bit_state_t state_q;
	logic [ADDR_BITS-1:0]   slot_addr_q;
	logic [ADDR_BITS-1:0]   wp_q;

	bspack_pkg::wr_list_t   list;
	bspack_pkg::bit_state_t state_nxt;
	logic [ADDR_BITS-1:0]   slot_addr_nxt;
	logic [ADDR_BITS-1:0]   wp_nxt;
	logic                   free;
	logic                   advance;
	logic                   take;

	assign advance    = valid_s1 && free;
	assign item_stall = valid_s1 && !free;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// commit the packer state when the item moves into the result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.shift_byte <= bspack_pkg::SHIFT_RESET;
			state_q.pend       <= 3'd0;
			state_q.slot_open  <= 1'b0;
			slot_addr_q        <= '0;
			wp_q               <= '0;
		end else if (advance) begin
			state_q     <= state_nxt;
			slot_addr_q <= slot_addr_nxt;
			wp_q        <= wp_nxt;
		end
	end

	bspack_encode #(
		.ADDR_BITS(ADDR_BITS)
	) u_encode (
		.item          (item_s1),
		.cur           (state_q),
		.slot_addr     (slot_addr_q),
		.wp            (wp_q),
		.list          (list),
		.nxt           (state_nxt),
		.slot_addr_nxt (slot_addr_nxt),
		.wp_nxt        (wp_nxt)
	);

	bspack_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (valid_s1),
		.list         (list),
		.free         (free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

// ----- rtl/core/bspack_encode.sv -----
// Combinational encoder: turns one item and the packer state into its byte writes.
`default_nettype none
module bspack_encode #(
	parameter int ADDR_BITS = 17
) (
	input  wire bspack_pkg::in_item_t   item,
	input  wire bspack_pkg::bit_state_t cur,
	input  wire logic [ADDR_BITS-1:0]   slot_addr,
	input  wire logic [ADDR_BITS-1:0]   wp,
	output bspack_pkg::wr_list_t        list,
	output bspack_pkg::bit_state_t      nxt,
	output logic [ADDR_BITS-1:0]        slot_addr_nxt,
	output logic [ADDR_BITS-1:0]        wp_nxt
);

	logic [4:0]  n_sat;
	logic [4:0]  code_n;
	logic [23:0] code_val;
	logic [23:0] rev;
	logic [31:0] s;
	logic [31:0] pend_bits;
	logic [31:0] stream;
	logic [4:0]  total;
	logic [1:0]  m;
	logic [2:0]  rem;
	logic [7:0]  tb;
	logic [15:0] tail;
	logic [7:0]  code_shift;
	logic [4:0]  lit_round;
	logic [1:0]  lb;
	logic        res;
	logic [2:0]  lit_cnt;

	assign n_sat = (item.bit_count > 5'(bspack_pkg::MAX_SYMBOL_BITS))
		? 5'(bspack_pkg::MAX_SYMBOL_BITS) : item.bit_count;

	// flush pushes one-bits until the pending byte completes
	always_comb begin
		if (item.opcode == bspack_pkg::OP_FLUSH) begin
			code_n   = (cur.pend == 3'd0) ? 5'd0 : 5'(4'd8 - {1'b0, cur.pend});
			code_val = '1;
		end else begin
			code_n   = n_sat;
			code_val = item.sym_value;
		end
	end

	always_comb begin
		for (int i = 0; i < 24; i++) begin
			rev[i] = code_val[23-i];
		end
	end

	// stream holds pending bits then new bits, first pushed bit at bit 0
	assign s         = {8'd0, rev} >> (5'd24 - code_n);
	assign pend_bits = {24'd0, cur.shift_byte >> (4'd8 - {1'b0, cur.pend})};
	assign stream    = pend_bits | (s << cur.pend);
	assign total     = {2'd0, cur.pend} + code_n;
	assign m         = total[4:3];
	assign rem       = total[2:0];
	assign tb        = stream[{m, 3'b000} +: 8];
	assign tail      = {8'd0, tb} << (4'd8 - {1'b0, rem});
	assign code_shift = tail[7:0] | (8'hFF >> rem);

	assign lit_round = n_sat + 5'd7;
	assign lb        = lit_round[4:3];
	assign res       = (cur.pend != 3'd0) && !cur.slot_open;
	assign lit_cnt   = {2'd0, res} + {1'b0, lb};

	always_comb begin
		list          = '0;
		nxt           = cur;
		slot_addr_nxt = slot_addr;
		wp_nxt        = wp;
		case (item.opcode)
			bspack_pkg::OP_CODE, bspack_pkg::OP_FLUSH: begin
				for (int j = 0; j < 3; j++) begin
					if (j < int'(m)) begin
						list.entry[j].we   = 1'b1;
						list.entry[j].data = stream[8*j +: 8];
						if (j == 0 && cur.slot_open) begin
							list.entry[j].addr = bspack_pkg::OUT_ADDR_W'(slot_addr);
						end else begin
							list.entry[j].addr = bspack_pkg::OUT_ADDR_W'(
								wp + ADDR_BITS'(j) - ADDR_BITS'(cur.slot_open));
						end
					end
				end
				list.cnt       = {1'b0, m};
				nxt.shift_byte = code_shift;
				nxt.pend       = rem;
				nxt.slot_open  = cur.slot_open && (m == 2'd0);
				wp_nxt = wp + ADDR_BITS'(m)
					- ADDR_BITS'(cur.slot_open && (m != 2'd0));
			end
			bspack_pkg::OP_LITERAL: begin
				for (int e = 0; e < bspack_pkg::MAX_RESULTS; e++) begin
					if (e == 0 && res) begin
						list.entry[e].we   = 1'b1;
						list.entry[e].addr = bspack_pkg::OUT_ADDR_W'(wp);
						list.entry[e].data = bspack_pkg::SLOT_FILL;
					end else if (e - int'(res) < int'(lb)) begin
						list.entry[e].we   = 1'b1;
						list.entry[e].addr = bspack_pkg::OUT_ADDR_W'(wp + ADDR_BITS'(e));
						list.entry[e].data = item.sym_value[
							{2'(lb - 2'd1 - 2'(e - int'(res))), 3'b000} +: 8];
					end
				end
				list.cnt = lit_cnt;
				if (res) begin
					nxt.slot_open = 1'b1;
					slot_addr_nxt = wp;
				end
				wp_nxt = wp + ADDR_BITS'(lit_cnt);
			end
			default: begin
				list.cnt = 3'd0;
			end
		endcase
		// an item without writes still yields one empty result
		if (list.cnt == 3'd0) begin
			list.cnt = 3'd1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/bspack_outbuf.sv -----
// Result buffer: holds the writes of one item and hands them out one per cycle while result_stall is low.
`default_nettype none
module bspack_outbuf (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        load,
	input  wire bspack_pkg::wr_list_t  list,
	output logic                       free,
	output logic                       result_valid,
	input  wire                        result_stall,
	output bspack_pkg::out_item_t      result
);

	bspack_pkg::wr_entry_t entry_q [bspack_pkg::MAX_RESULTS];
	logic [2:0]            cnt_q;
	logic                  pop;

	assign result_valid = (cnt_q != 3'd0);
	assign pop          = result_valid && !result_stall;
	assign free         = (cnt_q == 3'd0) || (cnt_q == 3'd1 && !result_stall);

	assign result.write_enable = entry_q[0].we;
	assign result.write_addr   = entry_q[0].addr;
	assign result.write_data   = entry_q[0].data;
	assign result.last         = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load && free) begin
			cnt_q <= list.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// advance the queue toward the head on each transaction
	always_ff @(posedge clk) begin
		if (load && free) begin
			for (int k = 0; k < bspack_pkg::MAX_RESULTS; k++) begin
				entry_q[k] <= list.entry[k];
			end
		end else if (pop) begin
			for (int k = 0; k < bspack_pkg::MAX_RESULTS - 1; k++) begin
				entry_q[k] <= entry_q[k+1];
			end
		end
	end

endmodule
`default_nettype wire
